// ===== sv/wlvs_pkg.sv =====
package wlvs_pkg;

    localparam int SLOT_COUNT = 128;
    localparam int VALUE_BITS = 12;
    localparam int SEQ_BITS   = 8;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

    localparam logic MODE_RECOVER = 1'b0;
    localparam logic MODE_WRITE   = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [11:0] data_word;
    } in_t;

    typedef struct packed {
        logic [11:0] stored_value;
        logic [6:0]  slot_index;
        logic        did_write;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_VRD,
        ST_WCHK,
        ST_RESP
    } state_t;

endpackage

// ===== sv/wear_leveled_value_store.sv =====
// Wear-levelled store for one small value kept in a ring of slots.
// Input channel s_*: one request per item, mode selects recover (scan the
// ring for the newest slot) or write (save a value into the next slot).
// Result channel m_*: exactly one result per request: value at the current
// slot, the slot index and whether a new slot was written.
// A recover request steps the sequence memory read port through the ring one
// slot per cycle and compares each byte with the previous one, stopping at the
// first break in the sequence or after a full pass.
// A write request reads both memories at the current slot, then compares and,
// only if the value differs, writes into the next slot.
// One request is worked on at a time; s_ready is high only while idle, so a
// new request is taken only after the last result enters the output register.
// A finished result sits in the output register until taken; a new request
// may be accepted meanwhile, and its result waits until m_ready frees the
// register.
// Reset clears a per-slot valid vector at once, so every slot reads as
// erased (all ones) straight after reset; no clearing pass is needed.
module wear_leveled_value_store (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  wlvs_pkg::in_t    s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output wlvs_pkg::out_t   m_data
);

    wlvs_pkg::state_t state_reg, state_next;

    logic [wlvs_pkg::SLOT_W-1:0]     cur_reg, cur_next;
    logic [wlvs_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [wlvs_pkg::SEQ_BITS-1:0]   prev_reg, prev_next;
    logic [wlvs_pkg::VALUE_BITS-1:0] data_reg;
    logic [wlvs_pkg::SLOT_COUNT-1:0] valid_reg;
    wlvs_pkg::out_t                  res_reg, res_next;
    wlvs_pkg::out_t                  m_data_reg;
    logic                            m_valid_reg;

    logic                            seq_re, val_re, mem_we;
    logic [wlvs_pkg::SLOT_W-1:0]     seq_raddr, val_raddr, waddr;
    logic [wlvs_pkg::SEQ_BITS-1:0]   seq_rdata, seq_eff, seq_wdata;
    logic [wlvs_pkg::VALUE_BITS-1:0] val_rdata, val_eff;
    logic                            seq_vld_reg, val_vld_reg;
    logic [wlvs_pkg::SLOT_W-1:0]     slot_succ;
    logic [wlvs_pkg::CNT_W-1:0]      cnt_inc;
    logic                            s_fire, load_out;

    wlvs_ram #(.WIDTH(wlvs_pkg::SEQ_BITS), .DEPTH(wlvs_pkg::SLOT_COUNT)) u_seq_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata (seq_wdata),
        .re    (seq_re),
        .raddr (seq_raddr),
        .rdata (seq_rdata)
    );

    wlvs_ram #(.WIDTH(wlvs_pkg::VALUE_BITS), .DEPTH(wlvs_pkg::SLOT_COUNT)) u_val_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata (data_reg),
        .re    (val_re),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    // unwritten slots read as erased
    assign seq_eff = seq_vld_reg ? seq_rdata : '1;
    assign val_eff = val_vld_reg ? val_rdata : '1;

    assign slot_succ = (cur_reg == wlvs_pkg::SLOT_W'(wlvs_pkg::SLOT_COUNT - 1)) ?
                       '0 : cur_reg + 1'b1;
    assign cnt_inc   = cnt_reg + 1'b1;

    assign s_ready = (state_reg == wlvs_pkg::ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cur_next   = cur_reg;
        cnt_next   = cnt_reg;
        prev_next  = prev_reg;
        res_next   = res_reg;
        seq_re     = 1'b0;
        val_re     = 1'b0;
        seq_raddr  = cur_reg;
        val_raddr  = cur_reg;
        mem_we     = 1'b0;
        waddr      = slot_succ;
        seq_wdata  = seq_eff + 1'b1;
        load_out   = 1'b0;
        case (state_reg)
            wlvs_pkg::ST_IDLE: begin
                if (s_fire) begin
                    cnt_next = '0;
                    if (s_data.mode == wlvs_pkg::MODE_RECOVER) begin
                        seq_re     = 1'b1;
                        seq_raddr  = '0;
                        state_next = wlvs_pkg::ST_SCAN;
                    end else begin
                        seq_re     = 1'b1;
                        val_re     = 1'b1;
                        state_next = wlvs_pkg::ST_WCHK;
                    end
                end
            end
            wlvs_pkg::ST_SCAN: begin
                // byte of slot cnt_reg (wrapped) is on the read port
                seq_re    = 1'b1;
                seq_raddr = (cnt_inc == wlvs_pkg::CNT_W'(wlvs_pkg::SLOT_COUNT)) ?
                            '0 : wlvs_pkg::SLOT_W'(cnt_inc);
                cnt_next  = cnt_inc;
                prev_next = seq_eff;
                if (cnt_reg != '0) begin
                    if (seq_eff != prev_reg + 1'b1) begin
                        cur_next   = wlvs_pkg::SLOT_W'(cnt_reg - 1'b1);
                        val_re     = 1'b1;
                        val_raddr  = wlvs_pkg::SLOT_W'(cnt_reg - 1'b1);
                        state_next = wlvs_pkg::ST_VRD;
                    end else if (cnt_reg == wlvs_pkg::CNT_W'(wlvs_pkg::SLOT_COUNT)) begin
                        cur_next   = '0;
                        val_re     = 1'b1;
                        val_raddr  = '0;
                        state_next = wlvs_pkg::ST_VRD;
                    end
                end
            end
            wlvs_pkg::ST_VRD: begin
                res_next.stored_value = 12'(val_eff);
                res_next.slot_index   = 7'(cur_reg);
                res_next.did_write    = 1'b0;
                state_next            = wlvs_pkg::ST_RESP;
            end
            wlvs_pkg::ST_WCHK: begin
                if (val_vld_reg && (val_rdata == data_reg)) begin
                    res_next.stored_value = 12'(val_eff);
                    res_next.slot_index   = 7'(cur_reg);
                    res_next.did_write    = 1'b0;
                end else begin
                    mem_we                = 1'b1;
                    cur_next              = slot_succ;
                    res_next.stored_value = 12'(data_reg);
                    res_next.slot_index   = 7'(slot_succ);
                    res_next.did_write    = 1'b1;
                end
                state_next = wlvs_pkg::ST_RESP;
            end
            wlvs_pkg::ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = wlvs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wlvs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= wlvs_pkg::ST_IDLE;
            cur_reg     <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            if (mem_we) begin
                valid_reg[waddr] <= 1'b1;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        prev_reg <= prev_next;
        res_reg  <= res_next;
        if (s_fire) begin
            data_reg <= wlvs_pkg::VALUE_BITS'(s_data.data_word);
        end
        if (seq_re) begin
            seq_vld_reg <= valid_reg[seq_raddr];
        end
        if (val_re) begin
            val_vld_reg <= valid_reg[val_raddr];
        end
        if (load_out) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== sv/wlvs_ram.sv =====
module wlvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/wlvs_checker.sv =====
module wlvs_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input wlvs_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input wlvs_pkg::out_t m_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one request in flight at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    // a result only appears once the sequencer has finished a request
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result without finished request");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.slot_index < 7'(wlvs_pkg::SLOT_COUNT - 1)) ||
                    (m_data.slot_index == 7'(wlvs_pkg::SLOT_COUNT - 1)))
        else $error("slot index out of range");

endmodule

bind wear_leveled_value_store wlvs_checker u_wlvs_checker (.*);

// ===== bench/tb_wear_leveled_value_store.sv =====
module tb_wear_leveled_value_store;
    import wlvs_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = SLOT_COUNT + 12;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    wear_leveled_value_store DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // predicted contents of the ring
    logic [15:0] slot_words [SLOT_COUNT];
    logic [SEQ_BITS-1:0] slot_seqs [SLOT_COUNT];
    logic [SLOT_W-1:0] live_slot;

    out_t pending_results [$];
    out_t oldest_result;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_req = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int fail_count = 0;
    int requests_sent = 0;
    int recovers_sent = 0;
    int words_stored = 0;
    int unchanged_writes = 0;
    int ring_wraps = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic logic [SLOT_W-1:0] slot_after(logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic out_t predict_store_step(in_t req);
        out_t res;
        logic [SLOT_W-1:0] pos;
        logic [SEQ_BITS-1:0] want_seq;
        logic [SEQ_BITS-1:0] prev_seq;
        logic [15:0] word;
        bit found;
        res = '0;
        word = 16'(req.data_word);
        if (req.mode == MODE_RECOVER) begin
            pos = '0;
            found = 1'b0;
            for (int i = 0; i < SLOT_COUNT && !found; i++) begin
                want_seq = slot_seqs[pos] + 1'b1;
                if (want_seq != slot_seqs[slot_after(pos)])
                    found = 1'b1;
                else
                    pos = slot_after(pos);
            end
            live_slot = pos;
        end else if (slot_words[live_slot] != word) begin
            prev_seq = slot_seqs[live_slot];
            live_slot = slot_after(live_slot);
            slot_words[live_slot] = word;
            slot_seqs[live_slot] = prev_seq + 1'b1;
            res.did_write = 1'b1;
        end
        res.stored_value = slot_words[live_slot][VALUE_BITS-1:0];
        res.slot_index = live_slot;
        return res;
    endfunction

    task automatic send_request(in_t req);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_store_step(req));
        requests_sent++;
        if (req.mode == MODE_RECOVER)
            recovers_sent++;
    endtask

    task automatic send_write(logic [11:0] value);
        in_t req;
        req.mode = MODE_WRITE;
        req.data_word = value;
        send_request(req);
    endtask

    task automatic send_recover(logic [11:0] junk);
        in_t req;
        req.mode = MODE_RECOVER;
        req.data_word = junk;
        send_request(req);
    endtask

    // erased ring comes back as slot 0 with all ones
    task automatic test_erased_recover();
        send_recover(12'h000);
        send_recover(12'hfff);
    endtask

    // current slot still at reset value, so the first write lands in slot 1
    task automatic test_directed_writes();
        send_write(12'hfff);
        send_write(12'hfff);
        send_write(12'h000);
        send_write(12'h000);
        send_write(12'haaa);
        send_write(12'h555);
        send_write(12'h001);
        send_write(12'h800);
        send_write(12'h800);
    endtask

    task automatic test_recover_after_writes();
        send_recover(12'h5a5);
        send_write(slot_words[live_slot][11:0]);
        send_recover(12'h000);
        send_write(12'h7ff);
        send_recover(12'hfff);
        send_write(12'h7ff);
    endtask

    task automatic test_random_traffic(int src_pct, int dst_pct, int count);
        int pick;
        send_idle_pct = src_pct;
        recv_idle_pct = dst_pct;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 15)
                send_recover(12'($urandom_range(4095)));
            else if (pick < 25)
                send_write(slot_words[live_slot][11:0]);
            else
                send_write(12'($urandom_range(4095)));
        end
    endtask

    // output held back long enough for the input side to stall
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req = 300;
        for (int n = 0; n < 8; n++)
            send_write(12'($urandom_range(4095)));
        send_recover(12'h000);
    endtask

    always @(posedge aclk) begin
        if (hold_off_req != 0) begin
            hold_left = hold_off_req;
            hold_off_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request outstanding, actual %p", $time, m_data);
                fail_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                if (m_data.stored_value !== oldest_result.stored_value) begin
                    $display("%0t: stored_value expected %h actual %h", $time,
                             oldest_result.stored_value, m_data.stored_value);
                    fail_count++;
                end
                if (m_data.slot_index !== oldest_result.slot_index) begin
                    $display("%0t: slot_index expected %0d actual %0d", $time,
                             oldest_result.slot_index, m_data.slot_index);
                    fail_count++;
                end
                if (m_data.did_write !== oldest_result.did_write) begin
                    $display("%0t: did_write expected %b actual %b", $time,
                             oldest_result.did_write, m_data.did_write);
                    fail_count++;
                end
                if (oldest_result.did_write) begin
                    words_stored++;
                    if (oldest_result.slot_index == '0)
                        ring_wraps++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time,
                     pending_results.size());
            $display("wear_leveled_value_store test failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_words[i] = 16'hffff;
            slot_seqs[i] = '1;
        end
        live_slot = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_erased_recover();
        test_directed_writes();
        test_recover_after_writes();
        test_random_traffic(7, 83, 200);
        test_random_traffic(83, 7, 200);
        test_output_backpressure();
        test_random_traffic(0, 0, 200);

        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        unchanged_writes = requests_sent - recovers_sent - words_stored;
        $display("%0d requests: %0d recovers, %0d slot writes, %0d writes of an unchanged value",
                 requests_sent, recovers_sent, words_stored, unchanged_writes);
        $display("ring wrapped %0d times, %0d mismatches", ring_wraps, fail_count);
        if (fail_count == 0)
            $display("wear_leveled_value_store test passed");
        else
            $display("wear_leveled_value_store test failed");
        $finish;
    end

endmodule
